/* rtl/core/lst_pkg.sv */
// Shared types, status codes and label normalization for the label symbol table.
// No dependencies; imported by label_symbol_table and its testbench (lst_ram does not use it).
package lst_pkg;

	// Fixed field widths
	localparam int LABEL_W    = 64;
	localparam int LOC_W      = 16;
	localparam int STATUS_W   = 3;
	localparam int OUT_IDX_W  = 8;

	// Significant label bytes and default table size
	localparam int LABEL_BYTES  = 8;
	localparam int LST_CAPACITY = 256;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic               req_type;
		logic [LABEL_W-1:0] label;
		logic [LOC_W-1:0]   new_location;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_IDX_W-1:0] entry_index;
		logic [LOC_W-1:0]     location;
	} rsp_t;

	// Keep bytes up to the first zero byte, clear everything after it
	function automatic logic [LABEL_W-1:0] normalize_label(input logic [LABEL_W-1:0] raw);
		logic [LABEL_W-1:0] res;
		logic               ended;
		res   = '0;
		ended = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b < LABEL_BYTES && !ended) begin
				if (raw[8*b +: 8] == 8'h00) begin
					ended = 1'b1;
				end else begin
					res[8*b +: 8] = raw[8*b +: 8];
				end
			end
		end
		return res;
	endfunction

endpackage

/* rtl/core/label_symbol_table.sv */
// Label symbol table top level: request intake, linear search sequencer, result register.
// Depends on lst_pkg and lst_ram.
//
// A request is taken when start is high and busy is low. The label is normalized (bytes past
// the first zero byte cleared) and the stored entries are scanned in insertion order through
// the single read port of the entry RAM, one entry per cycle. A hit on entry i ends the search;
// a miss ends it after the last stored entry, or right away on an empty table. An insert that
// misses appends the entry in the closing cycle when the table is not full. The result is on
// rsp for exactly one cycle with done high and cannot be held off by the receiver; busy is
// already low in that cycle, so the next request may be taken alongside it. No clearing pass
// after reset: only the entry count is cleared, and entries at or above it are never used.
module label_symbol_table #(
	parameter int CAPACITY = lst_pkg::LST_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lst_pkg::req_t req,
	output logic          done,
	output lst_pkg::rsp_t rsp
);
	import lst_pkg::*;

	localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW      = $clog2(CAPACITY + 1);
	localparam int ENTRY_W = LABEL_W + LOC_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic               state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      ptr_q;
	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	logic               type_q;
	logic [LABEL_W-1:0] key_q;
	logic [LOC_W-1:0]   loc_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               scan;
	logic               issue;
	logic               hit;
	logic               miss_end;
	logic               finish;
	logic               full;
	logic               we;
	logic [ENTRY_W-1:0] rdata;
	logic [LABEL_W-1:0] rd_label;
	logic [LOC_W-1:0]   rd_loc;
	rsp_t               rsp_d;

	// Entry store: location in the high bits, normalized label in the low bits
	lst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[AW-1:0]),
		.wdata({loc_q, key_q}),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rdata)
	);

	assign rd_label = rdata[LABEL_W-1:0];
	assign rd_loc   = rdata[ENTRY_W-1:LABEL_W];

	// Search control
	assign accept   = start && (state_q == S_IDLE);
	assign scan     = (state_q == S_SCAN);
	assign issue    = (ptr_q != count_q);
	assign hit      = vld_s1 && (rd_label == key_q);
	assign miss_end = !vld_s1 && !issue;
	assign finish   = scan && (hit || miss_end);
	assign full     = (count_q == CW'(CAPACITY));
	assign we       = finish && !hit && (type_q == REQ_INSERT) && !full;

	// Result formation
	always_comb begin
		rsp_d = '0;
		if (hit) begin
			if (type_q == REQ_INSERT) begin
				rsp_d.status = ST_DUPLICATE;
			end else begin
				rsp_d.status      = ST_FOUND;
				rsp_d.entry_index = OUT_IDX_W'(addr_s1);
				rsp_d.location    = rd_loc;
			end
		end else if (type_q == REQ_INSERT) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.status      = ST_INSERTED;
				rsp_d.entry_index = OUT_IDX_W'(count_q);
			end
		end else begin
			rsp_d.status = ST_NOT_FOUND;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						state_q <= S_SCAN;
						ptr_q   <= '0;
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					vld_s1 <= issue && !finish;
					if (finish) begin
						state_q <= S_IDLE;
					end
					if (we) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					vld_s1  <= 1'b0;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[AW-1:0];
		if (accept) begin
			type_q <= req.req_type;
			key_q  <= normalize_label(req.label);
			loc_q  <= req.new_location;
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = scan;
	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result beat lasted more than one cycle");

	a_vld_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> scan)
		else $error("read data marked valid outside a search");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status == ST_INSERTED) |-> (count_q == $past(count_q) + 1'b1))
		else $error("insert reported without count advance");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without entering search");

endmodule

/* rtl/core/lst_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; instanced by the label symbol table for its entry store.
module lst_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* test/label_symbol_table_tb.sv */
// Self-checking testbench for label_symbol_table: directed and random inserts and lookups.
// Depends on lst_pkg for the request/response structs and codes, and on the RTL of the block.
// The table contents are mirrored here, and each response beat is checked against them.
module label_symbol_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lst_pkg::*;

	localparam int MAX_GAP        = 15;
	localparam int MAX_BURST      = 40;
	localparam int RANDOM_ITEMS   = 425;
	localparam int SETTLE_CYCLES  = LST_CAPACITY + 8;
	localparam int WATCHDOG_LIMIT = 8 * (LST_CAPACITY + 2 + MAX_GAP);

	typedef struct {
		req_t beat;
		bit   drain;	// wait for all responses before offering this beat
	} pending_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	pending_t pending_q[$];
	rsp_t     expected_rsp_q[$];

	// mirror of the symbol table
	logic [LABEL_W-1:0] sym_labels[$];
	logic [LOC_W-1:0]   sym_locs[$];

	// raw labels sent with insert requests, reused for hits and duplicates
	logic [LABEL_W-1:0] issued_labels[$];

	int error_count = 0;
	int n_accepted  = 0;
	int n_done_seen = 0;
	int idle_cycles = 0;
	int burst_left  = 1;
	int gap_left    = 0;
	int status_hits[5] = '{default: 0};

	label_symbol_table DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #2 clk = ~clk;

	// Apply one request to the mirror and return the response it must produce
	function automatic rsp_t table_answer(input req_t r);
		logic [LABEL_W-1:0] key;
		int                 hit_pos;
		rsp_t               ans;
		key = '0;
		for (int b = 0; b < LABEL_BYTES; b++) begin
			if (r.label[8*b +: 8] == 8'h00) break;
			key[8*b +: 8] = r.label[8*b +: 8];
		end
		hit_pos = -1;
		foreach (sym_labels[i]) begin
			if (hit_pos < 0 && sym_labels[i] == key) hit_pos = i;
		end
		ans = '0;
		if (r.req_type == REQ_INSERT) begin
			if (hit_pos >= 0) begin
				ans.status = ST_DUPLICATE;
			end else if (sym_labels.size() >= LST_CAPACITY) begin
				ans.status = ST_FULL;
			end else begin
				ans.status      = ST_INSERTED;
				ans.entry_index = OUT_IDX_W'(sym_labels.size());
				sym_labels.push_back(key);
				sym_locs.push_back(r.new_location);
			end
		end else if (hit_pos >= 0) begin
			ans.status      = ST_FOUND;
			ans.entry_index = OUT_IDX_W'(hit_pos);
			ans.location    = sym_locs[hit_pos];
		end else begin
			ans.status = ST_NOT_FOUND;
		end
		return ans;
	endfunction

	// Random label of len nonzero bytes, terminator, then optional junk past the end
	function automatic logic [LABEL_W-1:0] make_label(input int len, input bit tail_noise);
		logic [LABEL_W-1:0] lbl;
		lbl = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < len) begin
				lbl[8*b +: 8] = 8'($urandom_range(255, 1));
			end else if (b > len && tail_noise) begin
				lbl[8*b +: 8] = 8'($urandom);
			end
		end
		return lbl;
	endfunction

	// Same label, fresh junk after its terminator
	function automatic logic [LABEL_W-1:0] vary_tail(input logic [LABEL_W-1:0] base);
		logic [LABEL_W-1:0] lbl;
		bit                 ended;
		lbl   = base;
		ended = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (ended) begin
				lbl[8*b +: 8] = 8'($urandom);
			end else if (base[8*b +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return lbl;
	endfunction

	task automatic queue_item(input logic kind, input logic [LABEL_W-1:0] lbl,
			input logic [LOC_W-1:0] loc, input bit drain);
		pending_t p;
		p.beat.req_type     = kind;
		p.beat.label        = lbl;
		p.beat.new_location = loc;
		p.drain             = drain;
		pending_q.push_back(p);
		if (kind == REQ_INSERT) issued_labels.push_back(lbl);
	endtask

	// Driver: offers queued beats in bursts, predicts each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (done) n_done_seen++;
			if (start && !busy) begin
				expected_rsp_q.push_back(table_answer(req));
				n_accepted++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_q.size() == 0 ||
						(pending_q[0].drain && n_done_seen != n_accepted)) begin
					start <= 1'b0;
				end else begin
					req   <= pending_q[0].beat;
					start <= 1'b1;
					void'(pending_q.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(MAX_BURST, 1);
						gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_GAP, 1);
					end
				end
			end
		end
	end

	// Monitor: every response beat against the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: unexpected response: status %0d index %0d location %h",
					$time, rsp.status, rsp.entry_index, rsp.location);
				error_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				status_hits[want.status]++;
				if (rsp.status !== want.status || rsp.entry_index !== want.entry_index ||
						rsp.location !== want.location) begin
					$display("%0t: mismatch: expected status %0d index %0d location %h, got %0d %0d %h",
						$time, want.status, want.entry_index, want.location,
						rsp.status, rsp.entry_index, rsp.location);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int                 roll;
		bit                 drain;
		logic [LABEL_W-1:0] lbl;
		arst_n = 1'b0;

		// directed: empty table, terminator handling, extremes of label and location
		queue_item(REQ_LOOKUP, 64'h0, 16'h0000, 1'b0);
		queue_item(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
		queue_item(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
		queue_item(REQ_INSERT, 64'hA5A5_A5A5_A5A5_A500, 16'h0000, 1'b0);
		queue_item(REQ_INSERT, 64'h0, 16'h1234, 1'b0);
		queue_item(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF, 1'b0);
		queue_item(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0);
		queue_item(REQ_INSERT, 64'h5A5A_5A5A_5A00_4241, 16'h8001, 1'b0);
		queue_item(REQ_LOOKUP, 64'h0000_0000_0000_4241, 16'h0000, 1'b0);
		queue_item(REQ_INSERT, 64'h1234_5678_9A00_4241, 16'h7FFE, 1'b0);
		queue_item(REQ_LOOKUP, 64'h0000_0000_0041_4241, 16'h0000, 1'b0);
		queue_item(REQ_INSERT, 64'h8000_0000_0000_0001, 16'h0001, 1'b0);
		queue_item(REQ_INSERT, 64'h0101_0101_0101_0101, 16'hAAAA, 1'b0);
		queue_item(REQ_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 16'h5555, 1'b0);
		queue_item(REQ_INSERT, 64'h8080_8080_8080_8080, 16'hFFFF, 1'b0);
		queue_item(REQ_LOOKUP, 64'h0101_0101_0101_0100, 16'h0000, 1'b0);
		queue_item(REQ_LOOKUP, 64'h0101_0101_0101_0101, 16'h0000, 1'b0);
		queue_item(REQ_LOOKUP, 64'h0000_0000_0000_0001, 16'h0000, 1'b0);
		queue_item(REQ_LOOKUP, 64'h8080_8080_8080_8080, 16'h0000, 1'b0);
		queue_item(REQ_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7E, 16'h0000, 1'b0);
		queue_item(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0);

		// random: mostly well-formed labels, enough inserts to fill the table
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll  = $urandom_range(99);
			drain = (n == 0) || (n % 120 == 60);
			if (roll < 60) begin
				lbl = make_label($urandom_range(8, 1), 1'($urandom_range(1, 0)));
				queue_item(REQ_INSERT, lbl, 16'($urandom), drain);
			end else if (roll < 68) begin
				lbl = vary_tail(issued_labels[$urandom_range(issued_labels.size() - 1)]);
				queue_item(REQ_INSERT, lbl, 16'($urandom), drain);
			end else if (roll < 88) begin
				lbl = vary_tail(issued_labels[$urandom_range(issued_labels.size() - 1)]);
				queue_item(REQ_LOOKUP, lbl, 16'($urandom), drain);
			end else if (roll < 94) begin
				lbl = make_label($urandom_range(8, 0), 1'($urandom_range(1, 0)));
				queue_item(REQ_LOOKUP, lbl, 16'($urandom), drain);
			end else begin
				lbl = {$urandom, $urandom};
				queue_item(1'($urandom_range(1, 0)), lbl, 16'($urandom), drain);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || start || expected_rsp_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_rsp_q.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
			error_count += expected_rsp_q.size();
		end
		$display("%0d requests: %0d inserted, %0d duplicate, %0d found, %0d not found, %0d full",
			n_accepted, status_hits[ST_INSERTED], status_hits[ST_DUPLICATE],
			status_hits[ST_FOUND], status_hits[ST_NOT_FOUND], status_hits[ST_FULL]);
		$display("table holds %0d of %0d entries, %0d errors", sym_labels.size(), LST_CAPACITY,
			error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/lst_pkg.sv
rtl/core/lst_ram.sv
rtl/core/label_symbol_table.sv
test/label_symbol_table_tb.sv
